@@ rtl/three_class_task_scheduler_assert.svh @@
// Assertion macros shared by the scheduler checker
`ifndef THREE_CLASS_TASK_SCHEDULER_ASSERT_SVH
`define THREE_CLASS_TASK_SCHEDULER_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define TCTS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent
`define TCTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/tcts_pkg.sv @@
// Shared types and codes of the three-class task scheduler
package tcts_pkg;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int RING_DEPTH_DEF  = 8;
  localparam int LIST_DEPTH_DEF  = 32;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_PROCESS = 2'd1;
  localparam logic [1:0] OP_PROMOTE = 2'd2;

  localparam logic [1:0] CLS_STACK = 2'd0;
  localparam logic [1:0] CLS_RING  = 2'd1;
  localparam logic [1:0] CLS_LIST  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_LOST      = 3'd4;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  pri;
  } task_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // perform the operation latched in the datapath
    logic load;   // capture the request word
  } tcts_cmd_t;
endpackage

@@ rtl/tcts_datapath.sv @@
// Task stores, shift-cell list and result formation
module tcts_datapath import tcts_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  tcts_cmd_t   cmd,
  input  logic [23:0] in_word,
  output logic [23:0] res_word
);
  localparam int SW = $clog2(STACK_DEPTH + 1);
  localparam int SA = $clog2(STACK_DEPTH);
  localparam int RA = $clog2(RING_DEPTH);
  localparam int LW = $clog2(LIST_DEPTH + 1);

  logic [1:0]  op, cls;
  task_t       req;
  task_t       stack_mem [STACK_DEPTH];
  task_t       ring_mem  [RING_DEPTH];
  task_t       list_cell [LIST_DEPTH];
  logic [SW-1:0] stack_count;
  logic [RA-1:0] ring_head, ring_tail;
  logic [LW-1:0] list_count;

  function automatic logic [RA-1:0] rnext(input logic [RA-1:0] i);
    rnext = (32'(i) + 1 >= RING_DEPTH) ? '0 : RA'(32'(i) + 1);
  endfunction

  // per-cell compare: entry occupied, priority greater, id match
  logic [LIST_DEPTH-1:0] occ, gt, hit, hit_first;
  always_comb begin
    for (int k = 0; k < LIST_DEPTH; k++) begin
      occ[k] = (LW'(k) < list_count);
      gt[k]  = occ[k] && (list_cell[k].pri > req.pri);
      hit[k] = occ[k] && (list_cell[k].id == req.id);
    end
    hit_first = hit & ~(hit - 1'b1);
  end

  // value each cell takes on insert: its lower neighbour while that one moves up,
  // else the new task
  task_t ins_val [LIST_DEPTH];
  always_comb begin
    ins_val[0] = req;
    for (int k = 1; k < LIST_DEPTH; k++)
      ins_val[k] = gt[k-1] ? list_cell[k-1] : req;
  end

  logic stack_full, ring_full, ring_empty, list_full, found;
  assign stack_full = (32'(stack_count) >= STACK_DEPTH);
  assign ring_full  = (rnext(ring_tail) == ring_head);
  assign ring_empty = (ring_head == ring_tail);
  assign list_full  = (32'(list_count) >= LIST_DEPTH);
  assign found      = |hit;

  // removal mask: cells at and above the removed one take their upper neighbour
  logic [LIST_DEPTH-1:0] rm_mask;
  logic                  do_remove, do_insert;
  task_t                 taken;
  always_comb begin
    taken      = list_cell[0];
    rm_mask[0] = (op == OP_PROCESS) | hit_first[0];
    for (int k = 0; k < LIST_DEPTH; k++)
      if (hit_first[k]) taken = list_cell[k];
    for (int k = 1; k < LIST_DEPTH; k++)
      rm_mask[k] = (op == OP_PROCESS) | rm_mask[k-1] | hit_first[k];
    if (op == OP_PROCESS) taken = list_cell[0];
    do_remove = cmd.exec && ((op == OP_PROCESS && stack_count == '0 && ring_empty &&
                list_count != '0) || (op == OP_PROMOTE && found));
    do_insert = cmd.exec && op == OP_INSERT && cls == CLS_LIST && !list_full;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= in_word[1:0];
      cls <= in_word[3:2];
      req <= {in_word[19:4], in_word[23:20]};
    end
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (do_insert) begin
        if (gt[k] || LW'(k) == list_count) list_cell[k] <= ins_val[k];
      end else if (do_remove && rm_mask[k] && k + 1 < LIST_DEPTH) begin
        list_cell[k] <= list_cell[(k + 1) % LIST_DEPTH];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= '0;
      ring_head   <= '0;
      ring_tail   <= '0;
      list_count  <= '0;
      res_word    <= '0;
    end else if (cmd.exec) begin
      unique case (op)
        OP_INSERT: begin
          case (cls)
            CLS_STACK: if (stack_full) res_word <= {21'd0, ST_FULL};
                       else begin
                         res_word <= '0;
                         stack_mem[stack_count[SA-1:0]] <= req;
                         stack_count <= stack_count + 1'b1;
                       end
            CLS_RING:  if (ring_full) res_word <= {21'd0, ST_FULL};
                       else begin
                         res_word <= '0;
                         ring_mem[ring_tail] <= req;
                         ring_tail <= rnext(ring_tail);
                       end
            CLS_LIST:  if (list_full) res_word <= {21'd0, ST_FULL};
                       else begin
                         res_word <= '0;
                         list_count <= list_count + 1'b1;
                       end
            default: res_word <= '0;
          endcase
        end
        OP_PROCESS: begin
          if (stack_count != '0) begin
            stack_count <= stack_count - 1'b1;
            res_word <= {stack_mem[SA'(stack_count - 1'b1)], 1'b0, ST_OK};
          end else if (!ring_empty) begin
            res_word <= {ring_mem[ring_head], 1'b0, ST_OK};
            ring_head <= rnext(ring_head);
          end else if (list_count != '0) begin
            res_word <= {taken, 1'b0, ST_OK};
            list_count <= list_count - 1'b1;
          end else res_word <= {21'd0, ST_EMPTY};
        end
        OP_PROMOTE: begin
          if (!found) res_word <= {21'd0, ST_NOT_FOUND};
          else begin
            list_count <= list_count - 1'b1;
            if (stack_full) res_word <= {21'd0, ST_LOST};
            else begin
              res_word <= '0;
              stack_mem[stack_count[SA-1:0]] <= taken;
              stack_count <= stack_count + 1'b1;
            end
          end
        end
        default: res_word <= '0;
      endcase
    end
  end
endmodule

@@ rtl/tcts_ctrl.sv @@
// Handshake controller: load, execute, present result
module tcts_ctrl import tcts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output tcts_cmd_t cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state, state_next;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_valid = (state == S_OUT);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state == S_EXEC);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

@@ rtl/three_class_task_scheduler.sv @@
// Top level of the three-class task scheduler
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | operation[1:0], task_class[3:2], task_id[19:4], task_priority[23:20]
//  m_axis  | out | status[2:0], pad[3], served_id[19:4], served_priority[23:20]
// Each word passes in turn through load, execute and present-result steps.
// The execute cycle is set by the shift-cell list, which compares, shifts
// and removes across all cells at once.
// Reset (rst, synchronous) empties all stores; no clearing pass.
// A stalled result holds the block; no new word is taken until it leaves.
module three_class_task_scheduler import tcts_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int RING_DEPTH  = RING_DEPTH_DEF,
  parameter int LIST_DEPTH  = LIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // operation, task_class, task_id, task_priority
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status, zero bit, served_id, served_priority
);
  tcts_cmd_t   cmd;
  logic [23:0] res_word;

  tcts_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd
  );

  tcts_datapath #(
    .STACK_DEPTH(STACK_DEPTH), .RING_DEPTH(RING_DEPTH), .LIST_DEPTH(LIST_DEPTH)
  ) u_dp (
    .clk, .rst, .cmd,
    .in_word(s_axis_tdata),
    .res_word
  );

  // datapath keeps task as {id, pri}; swap to output order
  assign m_axis_tdata = {res_word[7:4], res_word[23:8], 1'b0, res_word[2:0]};
  // (res_word[3] is always zero: status only uses three bits)
endmodule

@@ rtl/tcts_checker.sv @@
// Port-level checker for the scheduler, bound to the top level
`include "three_class_task_scheduler_assert.svh"
module tcts_checker import tcts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  `TCTS_ASSERT_IMP(a_no_overlap, clk, rst, m_axis_tvalid, !s_axis_tready)
  `TCTS_ASSERT_IMP(a_status_range, clk, rst, m_axis_tvalid, m_axis_tdata[2:0] <= ST_LOST)
  `TCTS_ASSERT_IMP(a_served_zero, clk, rst, m_axis_tvalid && m_axis_tdata[2:0] != ST_OK, m_axis_tdata[23:4] == 20'd0)
  `TCTS_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind three_class_task_scheduler tcts_checker u_chk (
  .clk, .rst, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

@@ tb/tb_three_class_task_scheduler.sv @@
// Self-checking testbench for the three-class task scheduler
`timescale 1ns / 1ps

// Scoreboard: keeps a copy of the three stores and the results still owed
class sched_scoreboard;
  logic [19:0] stack_q[$];
  logic [19:0] ring_q[$];
  logic [19:0] list_q[$];
  logic [23:0] owed_q[$];
  int errors;
  int served;
  int cnt_status[8];

  // predict the result of one accepted request word
  function void note_request(logic [23:0] w);
    logic [1:0] op, cls;
    logic [15:0] id;
    logic [3:0] pri;
    logic [19:0] ent, got;
    logic [2:0] st;
    int pos;
    op = w[1:0]; cls = w[3:2]; id = w[19:4]; pri = w[23:20];
    ent = {id, pri};
    st = tcts_pkg::ST_OK;
    got = '0;
    pos = -1;
    if (op == tcts_pkg::OP_INSERT) begin
      if (cls == tcts_pkg::CLS_STACK) begin
        if (stack_q.size() >= 8) st = tcts_pkg::ST_FULL;
        else stack_q.push_back(ent);
      end else if (cls == tcts_pkg::CLS_RING) begin
        if (ring_q.size() >= 7) st = tcts_pkg::ST_FULL;
        else ring_q.push_back(ent);
      end else if (cls == tcts_pkg::CLS_LIST) begin
        if (list_q.size() >= 32) st = tcts_pkg::ST_FULL;
        else begin
          // go after every entry of equal or more urgent priority
          pos = list_q.size();
          while (pos > 0 && list_q[pos-1][3:0] > pri) pos--;
          list_q.insert(pos, ent);
        end
      end
    end else if (op == tcts_pkg::OP_PROCESS) begin
      if (stack_q.size() > 0) got = stack_q.pop_back();
      else if (ring_q.size() > 0) got = ring_q.pop_front();
      else if (list_q.size() > 0) got = list_q.pop_front();
      else st = tcts_pkg::ST_EMPTY;
    end else if (op == tcts_pkg::OP_PROMOTE) begin
      for (int i = 0; i < list_q.size(); i++)
        if (pos < 0 && list_q[i][19:4] == id) pos = i;
      if (pos < 0) st = tcts_pkg::ST_NOT_FOUND;
      else begin
        ent = list_q[pos];
        list_q.delete(pos);
        if (stack_q.size() >= 8) st = tcts_pkg::ST_LOST;
        else stack_q.push_back(ent);
      end
    end
    cnt_status[st]++;
    owed_q.push_back({got[3:0], got[19:4], 1'b0, st});
  endfunction

  function void check_result(logic [23:0] r);
    logic [23:0] e;
    if (owed_q.size() == 0) begin
      $error("unexpected result word %h", r);
      errors++;
      return;
    end
    e = owed_q.pop_front();
    served++;
    if (r[2:0] !== e[2:0]) begin
      $error("status: expected %0d, got %0d", e[2:0], r[2:0]); errors++;
    end
    if (r[3] !== 1'b0) begin
      $error("pad: expected 0, got %b", r[3]); errors++;
    end
    if (r[19:4] !== e[19:4]) begin
      $error("served_id: expected %0d, got %0d", e[19:4], r[19:4]); errors++;
    end
    if (r[23:20] !== e[23:20]) begin
      $error("served_priority: expected %0d, got %0d", e[23:20], r[23:20]); errors++;
    end
  endfunction
endclass

module tb_three_class_task_scheduler;
  import tcts_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // operation, task_class, task_id, task_priority
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // status, zero bit, served_id, served_priority

  sched_scoreboard sb;
  int  cycles;
  bit  hold_off;        // long receiver stall, raised by the stimulus
  int  sent;
  logic [15:0] recent_ids[$];   // ids already sent to the list, for promotes

  three_class_task_scheduler dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: stops the run with a failure if it does not finish in time
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_three_class_task_scheduler failed");
        $finish;
      end
    end
  end

  // Offer one request word, with a random gap first; hold valid until taken
  task automatic send_word(logic [1:0] op, logic [1:0] cls, logic [15:0] id,
                           logic [3:0] pri);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, id, cls, op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request({pri, id, cls, op});
    if (op == OP_INSERT && cls == CLS_LIST) recent_ids.push_back(id);
    if (recent_ids.size() > 40) void'(recent_ids.pop_front());
    sent++;
  endtask

  // Random word shaped towards deep behaviour: mostly legal ops, promotes mostly of
  // ids recently sent to the list, and now and then the unused codes
  task automatic send_random();
    int r;
    logic [1:0] op, cls;
    logic [15:0] id;
    logic [3:0] pri;
    r = $urandom_range(0, 99);
    cls = 2'($urandom_range(0, 2));
    id = 16'($urandom);
    pri = $urandom_range(0, 99) < 90 ? 4'($urandom_range(0, 10)) : 4'($urandom_range(0, 15));
    if (r < 45) op = OP_INSERT;
    else if (r < 78) op = OP_PROCESS;
    else if (r < 94) begin
      op = OP_PROMOTE;
      if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    end else begin
      op = 2'($urandom);
      cls = 2'($urandom);
    end
    send_word(op, cls, id, pri);
  endtask

  // Receiver: random stalls per word, plus a long hold-off when asked
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_off = 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty process, absent promote, field extremes, fill every store
    send_word(OP_PROCESS, CLS_STACK, 16'h0000, 4'h0);
    send_word(OP_PROMOTE, CLS_STACK, 16'hFFFF, 4'h0);
    send_word(OP_INSERT, CLS_LIST, 16'hFFFF, 4'hF);
    send_word(OP_INSERT, CLS_LIST, 16'h0000, 4'h0);
    send_word(OP_INSERT, CLS_LIST, 16'hA5A5, 4'hA);
    send_word(OP_INSERT, CLS_LIST, 16'h5A5A, 4'hA);   // equal priority goes after
    send_word(OP_INSERT, 2'd3, 16'h1234, 4'h5);       // unknown class ignored
    send_word(2'd3, 2'd3, 16'hFFFF, 4'hF);            // unknown op ignored
    for (int i = 0; i < 9; i++)                        // last is full
      send_word(OP_INSERT, CLS_STACK, 16'(i), 4'(i));
    for (int i = 0; i < 8; i++)                        // last is full
      send_word(OP_INSERT, CLS_RING, 16'(100 + i), 4'(i));
    send_word(OP_PROMOTE, CLS_STACK, 16'hA5A5, 4'h0); // stack full: task lost
    send_word(OP_PROCESS, CLS_STACK, 16'h0, 4'h0);
    send_word(OP_PROMOTE, CLS_STACK, 16'hFFFF, 4'h0); // promoted onto the stack
    // Drain everything, serving each class in turn
    for (int i = 0; i < 20; i++) send_word(OP_PROCESS, CLS_STACK, 16'h0, 4'h0);
    // Fill the list to overflow with random priorities
    for (int i = 0; i < 33; i++)
      send_word(OP_INSERT, CLS_LIST, 16'($urandom), 4'($urandom));

    // Random phase, with a long receiver hold-off phase in the middle
    for (int n = 0; n < 1300; n++) begin
      if (n == 600) hold_off = 1'b1;
      if (n == 602) hold_off = 1'b0;
      send_random();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.owed_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d request words sent, %0d results checked", sent, sb.served);
    $display("status mix ok/full/empty/not-found/lost: %0d/%0d/%0d/%0d/%0d",
             sb.cnt_status[0], sb.cnt_status[1], sb.cnt_status[2],
             sb.cnt_status[3], sb.cnt_status[4]);
    if (sb.errors == 0 && sb.owed_q.size() == 0)
      $display("tb_three_class_task_scheduler passed");
    else
      $display("tb_three_class_task_scheduler failed");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tcts_pkg.sv
rtl/tcts_datapath.sv
rtl/tcts_ctrl.sv
rtl/three_class_task_scheduler.sv
rtl/tcts_checker.sv
tb/tb_three_class_task_scheduler.sv
